@@ hw/rtl/pf_rgba_pkg.sv @@
`timescale 1ns / 1ps

package pf_rgba_pkg;

   typedef enum logic [2:0] {
      MODE_RGBA8888 = 3'd0,
      MODE_RGBA5551 = 3'd1,
      MODE_RGBA4444 = 3'd2,
      MODE_BGR888   = 3'd3,
      MODE_RGB565   = 3'd4,
      MODE_RGB888   = 3'd5
   } pixel_mode_type;

   localparam int unsigned MODE_W  = 3;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned GATH_W  = 24;
   localparam int unsigned POS_W   = 2;
   localparam int unsigned SIZE_W  = 3;

   localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

   // Bytes per source pixel; zero marks an unused mode.
   function automatic logic [SIZE_W-1:0] pixel_size(input logic [MODE_W-1:0] mode);
      logic [SIZE_W-1:0] size;
      case (pixel_mode_type'(mode))
         MODE_RGBA8888: size = 3'd4;
         MODE_RGBA5551: size = 3'd2;
         MODE_RGBA4444: size = 3'd2;
         MODE_RGB565:   size = 3'd2;
         MODE_BGR888:   size = 3'd3;
         MODE_RGB888:   size = 3'd3;
         default:       size = 3'd0;
      endcase
      return size;
   endfunction

endpackage

@@ hw/rtl/pixel_format_to_rgba8888.sv @@
`timescale 1ns / 1ps

// Byte stream to RGBA8888 converter. Each request carries one source byte;
// bytes are gathered little-endian into pixels of 4, 2 or 3 bytes according
// to the source format in the csr register (0 RGBA8888, 1 RGBA5551,
// 2 RGBA4444, 3 BGR888, 4 RGB565, 5 RGB888; 6 and 7 drop every byte). The
// byte that completes a pixel yields one 32-bit word, red in bits 7..0 and
// alpha in 31..24, from the result register in the cycle after its acceptance.
// One byte is accepted every cycle while the result side takes its words;
// the only state carried between bytes is the gather position and the
// partial pixel. A byte with tlast ends the buffer: a partial pixel is
// dropped and the completing pixel, if any, leaves with tlast set. Write
// the format only while the stream is idle.
module pixel_format_to_rgba8888
   import pf_rgba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [MODE_W-1:0]   csr_wr_data,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [BYTE_W-1:0]   req_tdata,   // in_byte
   input  logic                req_tlast,   // last_byte
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [WORD_W-1:0]   rsp_tdata,   // rgba_word
   output logic                rsp_tlast    // last_pixel
);

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [GATH_W-1:0] gath_ff, gath_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [SIZE_W-1:0] size;
   logic              restart;
   logic [POS_W-1:0]  pos_eff;
   logic [GATH_W-1:0] gath_eff;
   logic              complete;
   logic              accept;
   logic [WORD_W-1:0] full;
   logic [WORD_W-1:0] rgba;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign size     = pixel_size(mode_ff);
   assign restart  = {1'b0, pos_ff} >= size;
   assign pos_eff  = restart ? '0 : pos_ff;
   assign gath_eff = restart ? '0 : gath_ff;
   assign complete = (size != '0) && (({1'b0, pos_eff} + 3'd1) == size);
   assign full     = {{(WORD_W-GATH_W){1'b0}}, gath_eff}
                   | ({{(WORD_W-BYTE_W){1'b0}}, req_tdata} << {pos_eff, 3'b000});

   pf_rgba_convert u_convert (
      .mode  (mode_ff),
      .pixel (full),
      .rgba  (rgba)
   );

   always_comb begin
      mode_in      = csr_wr_en ? csr_wr_data : mode_ff;
      pos_in       = pos_ff;
      gath_in      = gath_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (accept) begin
         if (size == '0 || complete || req_tlast) begin
            pos_in  = '0;
            gath_in = '0;
         end else begin
            pos_in  = pos_eff + 2'd1;
            gath_in = full[GATH_W-1:0];
         end
         if (complete) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = rgba;
            rsp_last_in  = req_tlast;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RGBA8888;
         pos_ff       <= '0;
         gath_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         pos_ff       <= pos_in;
         gath_ff      <= gath_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // a fresh pixel has no gathered bytes
   a_gath_clear: assert property (@(posedge clock) disable iff (reset)
      pos_ff == '0 |-> gath_ff == '0)
      else $error("partial pixel bytes held at position zero");

   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> pos_ff == '0)
      else $error("gathering not restarted after last byte");

   a_unused_mode: assert property (@(posedge clock) disable iff (reset)
      accept && size == '0 |=> pos_ff == '0 && !$rose(rsp_valid_ff))
      else $error("unused mode gathered or produced a pixel");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept && complete))
      else $error("result raised without a completing byte");

   a_position_range: assert property (@(posedge clock) disable iff (reset)
      accept && !req_tlast && !complete && size != '0
         |=> {1'b0, pos_ff} < $past(size))
      else $error("gather position reached pixel size");

endmodule

@@ hw/rtl/pf_rgba_convert.sv @@
`timescale 1ns / 1ps

module pf_rgba_convert
   import pf_rgba_pkg::*;
(
   input  logic [MODE_W-1:0] mode,
   input  logic [WORD_W-1:0] pixel,
   output logic [WORD_W-1:0] rgba
);

   logic [4:0] r5, g5, b5, b5_565;
   logic [5:0] g6;
   logic [BYTE_W-1:0] r_w5, g_w5, b_w5, g_w6, b_w565;

   assign r5     = pixel[4:0];
   assign g5     = pixel[9:5];
   assign b5     = pixel[14:10];
   assign g6     = pixel[10:5];
   assign b5_565 = pixel[15:11];

   // widen by bit replication
   assign r_w5   = {r5, r5[4:2]};
   assign g_w5   = {g5, g5[4:2]};
   assign b_w5   = {b5, b5[4:2]};
   assign g_w6   = {g6, g6[5:4]};
   assign b_w565 = {b5_565, b5_565[4:2]};

   always_comb begin
      case (pixel_mode_type'(mode))
         MODE_RGBA8888: rgba = pixel;
         MODE_RGBA5551: rgba = {{BYTE_W{pixel[15]}}, b_w5, g_w5, r_w5};
         MODE_RGBA4444: rgba = {pixel[15:12], pixel[15:12], pixel[11:8], pixel[11:8],
                                pixel[7:4], pixel[7:4], pixel[3:0], pixel[3:0]};
         MODE_BGR888:   rgba = {ALPHA_OPAQUE, pixel[7:0], pixel[15:8], pixel[23:16]};
         MODE_RGB565:   rgba = {ALPHA_OPAQUE, b_w565, g_w6, r_w5};
         MODE_RGB888:   rgba = {ALPHA_OPAQUE, pixel[23:16], pixel[15:8], pixel[7:0]};
         default:       rgba = '0;
      endcase
   end

endmodule
